// ----- rtl/mmcs_pkg.sv -----
// Shared constants, types and request struct for the min-max contrast stretch
package mmcs_pkg;

  // pixel and level geometry
  localparam int PIXEL_BITS = 16;
  localparam int PORT_BITS  = 16;
  localparam int LEVEL_BITS = 8;
  localparam int STEP_BITS  = $clog2(LEVEL_BITS);

  typedef logic [PIXEL_BITS-1:0] pix_t;
  typedef logic [LEVEL_BITS-1:0] level_t;
  typedef logic [STEP_BITS-1:0]  step_t;

  localparam pix_t   PIX_MAX   = {PIXEL_BITS{1'b1}};
  localparam level_t LEVEL_MAX = {LEVEL_BITS{1'b1}};
  localparam step_t  STEP_LAST = step_t'(LEVEL_BITS - 1);

  // request kinds
  localparam logic KIND_MEASURE   = 1'b0;
  localparam logic KIND_NORMALISE = 1'b1;

  // request from the top level to the divider
  typedef struct packed {
    logic start;
    logic force_zero;
    logic force_max;
    logic last;
  } div_req_t;

endpackage

// ----- rtl/mmcs_div.sv -----
// Bit-serial restoring divider computing (num*255)/span, with output register
module mmcs_div
  import mmcs_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  input  pix_t     num,
  input  pix_t     span,
  output logic     busy,
  output logic     out_valid,
  input  logic     out_ready,
  output level_t   level,
  output logic     last_res
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_PREP = 2'd1;
  localparam logic [1:0] ST_STEP = 2'd2;
  localparam logic [1:0] ST_DONE = 2'd3;

  logic [1:0] state;
  step_t      cnt;
  pix_t       num_q;
  pix_t       span_q;
  pix_t       rem;
  level_t     lowbits;
  level_t     quo;
  logic       force_zero;
  logic       force_max;
  logic       last_q;

  logic [PIXEL_BITS+LEVEL_BITS-1:0] prod;
  logic [PIXEL_BITS+1:0]            trial;
  logic                             qbit;
  pix_t                             rem_next;
  level_t                           quo_next;
  level_t                           level_next;
  logic                             out_free;
  logic                             step_final;
  logic                             write_out;

  // numerator times 255 as a shift and subtract
  assign prod = {num_q, {LEVEL_BITS{1'b0}}} - {{LEVEL_BITS{1'b0}}, num_q};

  // one restoring step: bring down the next numerator bit and trial subtract
  assign trial    = {1'b0, rem, lowbits[LEVEL_BITS-1]} - {2'b00, span_q};
  assign qbit     = ~trial[PIXEL_BITS+1];
  assign rem_next = qbit ? trial[PIXEL_BITS-1:0]
                         : {rem[PIXEL_BITS-2:0], lowbits[LEVEL_BITS-1]};
  assign quo_next = {quo[LEVEL_BITS-2:0], qbit};

  // output handshake and result write
  assign out_free   = ~out_valid | out_ready;
  assign step_final = (state == ST_STEP) && (cnt == STEP_LAST);
  assign write_out  = out_free && (step_final || (state == ST_DONE));

  // saturation overrides the quotient
  always_comb begin
    if (force_max) begin
      level_next = LEVEL_MAX;
    end else if (force_zero) begin
      level_next = '0;
    end else if (state == ST_DONE) begin
      level_next = quo;
    end else begin
      level_next = quo_next;
    end
  end

  assign busy = (state != ST_IDLE);

  // sequencer and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (write_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (req.start) begin
            state <= ST_PREP;
          end
        end
        ST_PREP: begin
          cnt   <= '0;
          state <= ST_STEP;
        end
        ST_STEP: begin
          cnt <= cnt + step_t'(1);
          if (step_final) begin
            state <= out_free ? ST_IDLE : ST_DONE;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if ((state == ST_IDLE) && req.start) begin
      num_q      <= num;
      span_q     <= span;
      force_zero <= req.force_zero;
      force_max  <= req.force_max;
      last_q     <= req.last;
    end
    if (state == ST_PREP) begin
      rem     <= prod[PIXEL_BITS+LEVEL_BITS-1:LEVEL_BITS];
      lowbits <= prod[LEVEL_BITS-1:0];
      quo     <= '0;
    end
    if (state == ST_STEP) begin
      rem     <= rem_next;
      lowbits <= {lowbits[LEVEL_BITS-2:0], 1'b0};
      quo     <= quo_next;
    end
    if (write_out) begin
      level    <= level_next;
      last_res <= last_q;
    end
  end

endmodule

// ----- rtl/minmax_contrast_stretch.sv -----
// Min-max contrast stretch: running min/max over the measure pass, 8-bit levels after
// Measure requests update the running min/max when accepted and produce no result.
// Normalise requests register the operands, form the numerator, then run eight steps
// of the bit-serial divider, one quotient bit a cycle; no new request is taken meanwhile.
// The result is registered and held until taken.
// Synchronous reset sets min to all ones, max to zero and arms a fresh frame.
module minmax_contrast_stretch
  import mmcs_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 kind,
  input  logic [PORT_BITS-1:0] pixel,
  input  logic                 last,
  output logic                 out_valid,
  input  logic                 out_ready,
  output level_t               level,
  output logic                 last_res
);

  pix_t     low_seen;
  pix_t     high_seen;
  logic     fresh_frame;
  pix_t     pix;
  logic     accept;
  logic     busy;
  logic     flat;
  logic     below;
  logic     above;
  div_req_t req;

  assign pix      = pixel[PIXEL_BITS-1:0];
  assign in_ready = ~busy;
  assign accept   = in_valid & in_ready;

  // range checks against the measured window
  assign flat  = (high_seen <= low_seen);
  assign below = (pix <= low_seen);
  assign above = (pix >= high_seen);

  assign req.start      = accept && (kind == KIND_NORMALISE);
  assign req.force_zero = flat | below;
  assign req.force_max  = ~flat & ~below & above;
  assign req.last       = last;

  // running minimum and maximum
  always_ff @(posedge clk) begin
    if (rst) begin
      low_seen    <= PIX_MAX;
      high_seen   <= '0;
      fresh_frame <= 1'b1;
    end else if (accept) begin
      if (kind == KIND_MEASURE) begin
        if (fresh_frame) begin
          low_seen  <= pix;
          high_seen <= pix;
        end else begin
          if (pix < low_seen) begin
            low_seen <= pix;
          end
          if (pix > high_seen) begin
            high_seen <= pix;
          end
        end
        fresh_frame <= last;
      end else begin
        fresh_frame <= 1'b1;
      end
    end
  end

  // serial divider and result register
  mmcs_div u_div (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .num       (pix - low_seen),
    .span      (high_seen - low_seen),
    .busy      (busy),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .level     (level),
    .last_res  (last_res)
  );

endmodule
